>>> hdl/tzda_pkg.sv
// shared types, constants and calendar helpers for the time zone adjust block
package tzda_pkg;

    // configuration register indexes
    localparam logic [0:0] CFG_BIAS_HOURS   = 1'b0;
    localparam logic [0:0] CFG_BIAS_MINUTES = 1'b1;

    // year saturation bounds
    localparam logic [14:0] YEAR_MIN = 15'd1601;
    localparam logic [14:0] YEAR_MAX = 15'd30827;

    // divisibility by 25 over 15-bit years: y * inverse(25) mod 2^15 <= 32767 / 25
    localparam logic [14:0] INV_25     = 15'd23593;
    localparam logic [14:0] DIV25_LIMIT = 15'd1310;

    // minute, hour and month ranges
    localparam logic signed [7:0] MIN_SPAN  = 8'sd60;
    localparam logic signed [7:0] MIN_LAST  = 8'sd59;
    localparam logic signed [6:0] HOUR_SPAN = 7'sd24;
    localparam logic signed [6:0] HOUR_LAST = 7'sd23;
    localparam logic signed [5:0] MONTH_SPAN = 6'sd12;

    // month numbers used by name
    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_MAR = 4'd3;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_MAY = 4'd5;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_JUL = 4'd7;
    localparam logic [3:0] MONTH_AUG = 4'd8;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_OCT = 4'd10;
    localparam logic [3:0] MONTH_NOV = 4'd11;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    // request payloads
    typedef struct packed {
        logic [14:0] in_year;
        logic [3:0]  in_month;
        logic [4:0]  in_day;
        logic [4:0]  in_hour;
        logic [5:0]  in_minute;
    } t_in_item;

    typedef struct packed {
        logic [14:0] out_year;
        logic [3:0]  out_month;
        logic [4:0]  out_day;
        logic [4:0]  out_hour;
        logic [5:0]  out_minute;
        logic        month_valid;
    } t_out_item;

    // days in a month, zero for a month number outside 1..12
    function automatic logic [4:0] month_len(input logic is_leap, input logic [3:0] month);
        logic [4:0] len;
        begin
            unique case (month)
                MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
                MONTH_AUG, MONTH_OCT, MONTH_DEC: len = 5'd31;
                MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
                MONTH_FEB: len = is_leap ? 5'd29 : 5'd28;
                default: len = 5'd0;
            endcase
            return len;
        end
    endfunction

endpackage

>>> hdl/tzda_adjust.sv
// combinational offset add with minute, hour, day, month and year carries
module tzda_adjust (
    input  tzda_pkg::t_in_item   i_item,
    input  logic signed [4:0]    i_bias_hours,
    input  logic signed [6:0]    i_bias_minutes,
    output tzda_pkg::t_out_item  o_item
);

    logic signed [7:0]  minute_sum;
    logic signed [7:0]  minute_fix;
    logic signed [1:0]  minute_carry;
    logic signed [6:0]  hour_sum;
    logic signed [6:0]  hour_fix;
    logic signed [1:0]  hour_carry;
    logic [14:0]        div25_prod;
    logic               is_leap;
    logic [4:0]         dim;
    logic [4:0]         prev_len;
    logic [3:0]         prev_month;
    logic               valid;
    logic signed [6:0]  day_sum;
    logic signed [6:0]  day_fix;
    logic signed [1:0]  day_carry;
    logic signed [5:0]  month_sum;
    logic signed [5:0]  month_fix;
    logic signed [1:0]  month_carry;
    logic signed [16:0] year_sum;
    logic [14:0]        year_fix;

    // minute: add offset, wrap once into 0..59
    always_comb begin
        minute_sum = $signed({2'b00, i_item.in_minute}) + {i_bias_minutes[6], i_bias_minutes};
        if (minute_sum < 0) begin
            minute_fix   = minute_sum + tzda_pkg::MIN_SPAN;
            minute_carry = -2'sd1;
        end else if (minute_sum > tzda_pkg::MIN_LAST) begin
            minute_fix   = minute_sum - tzda_pkg::MIN_SPAN;
            minute_carry = 2'sd1;
        end else begin
            minute_fix   = minute_sum;
            minute_carry = 2'sd0;
        end
    end

    // hour: add offset and minute carry, wrap once into 0..23
    always_comb begin
        hour_sum = $signed({2'b00, i_item.in_hour})
                 + {{2{i_bias_hours[4]}}, i_bias_hours}
                 + {{5{minute_carry[1]}}, minute_carry};
        if (hour_sum < 0) begin
            hour_fix   = hour_sum + tzda_pkg::HOUR_SPAN;
            hour_carry = -2'sd1;
        end else if (hour_sum > tzda_pkg::HOUR_LAST) begin
            hour_fix   = hour_sum - tzda_pkg::HOUR_SPAN;
            hour_carry = 2'sd1;
        end else begin
            hour_fix   = hour_sum;
            hour_carry = 2'sd0;
        end
    end

    // leap year from the input year: by 4, and not by 25 unless also by 16
    assign div25_prod = 15'(i_item.in_year * tzda_pkg::INV_25);
    assign is_leap    = (i_item.in_year[1:0] == 2'b00)
                      && ((div25_prod > tzda_pkg::DIV25_LIMIT) || (i_item.in_year[3:0] == 4'd0));

    // month lengths: this month, and the one before (december before january)
    assign dim        = tzda_pkg::month_len(is_leap, i_item.in_month);
    assign valid      = (dim != 5'd0);
    assign prev_month = i_item.in_month - 4'd1;
    assign prev_len   = (i_item.in_month == tzda_pkg::MONTH_JAN) ? 5'd31
                      : tzda_pkg::month_len(is_leap, prev_month);

    // day: add hour carry, borrow the previous month or carry past this one
    always_comb begin
        day_sum = $signed({2'b00, i_item.in_day}) + {{5{hour_carry[1]}}, hour_carry};
        if (day_sum < 7'sd1) begin
            day_fix   = day_sum + $signed({2'b00, prev_len});
            day_carry = -2'sd1;
        end else if (day_sum > $signed({2'b00, dim})) begin
            day_fix   = day_sum - $signed({2'b00, dim});
            day_carry = 2'sd1;
        end else begin
            day_fix   = day_sum;
            day_carry = 2'sd0;
        end
    end

    // month: add day carry, wrap once into 1..12
    always_comb begin
        month_sum = $signed({2'b00, i_item.in_month}) + {{4{day_carry[1]}}, day_carry};
        if (month_sum < 6'sd1) begin
            month_fix   = month_sum + tzda_pkg::MONTH_SPAN;
            month_carry = -2'sd1;
        end else if (month_sum > tzda_pkg::MONTH_SPAN) begin
            month_fix   = month_sum - tzda_pkg::MONTH_SPAN;
            month_carry = 2'sd1;
        end else begin
            month_fix   = month_sum;
            month_carry = 2'sd0;
        end
    end

    // year: add month carry and saturate
    always_comb begin
        year_sum = $signed({2'b00, i_item.in_year}) + {{15{month_carry[1]}}, month_carry};
        if (year_sum < $signed({2'b00, tzda_pkg::YEAR_MIN})) begin
            year_fix = tzda_pkg::YEAR_MIN;
        end else if (year_sum > $signed({2'b00, tzda_pkg::YEAR_MAX})) begin
            year_fix = tzda_pkg::YEAR_MAX;
        end else begin
            year_fix = year_sum[14:0];
        end
    end

    // result assembly; an invalid month passes the date through
    always_comb begin
        o_item.out_minute  = minute_fix[5:0];
        o_item.out_hour    = hour_fix[4:0];
        o_item.month_valid = valid;
        if (valid) begin
            o_item.out_day   = day_fix[4:0];
            o_item.out_month = month_fix[3:0];
            o_item.out_year  = year_fix;
        end else begin
            o_item.out_day   = i_item.in_day;
            o_item.out_month = i_item.in_month;
            o_item.out_year  = i_item.in_year;
        end
    end

endmodule

>>> hdl/timezone_date_time_adjust_core.sv
// top level: bias registers, input register, adjust logic and result register
//
// Adds a signed time zone offset (hours and minutes, written through the
// configuration port) to a broken-down date and time. Each request is captured
// in an input register, adjusted by single-pass logic and held in a result
// register, so a request can be taken every cycle unless the result side
// holds back. Under back-pressure the result register holds and the input
// register fills, so up to two requests wait inside. Write the offset only
// while no request is in flight. A month outside 1..12 clears month_valid and
// passes the date fields through; minute and hour are still adjusted. For a
// valid month the year saturates to 1601..30827.
module timezone_date_time_adjust_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  tzda_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output tzda_pkg::t_out_item  o_out_data,
    input  logic                 i_cfg_we,
    input  logic [0:0]           i_cfg_index,
    input  logic [6:0]           i_cfg_wdata
);

    logic signed [4:0]    r_bias_hours;
    logic signed [6:0]    r_bias_minutes;
    logic                 r_in_valid;
    tzda_pkg::t_in_item   r_in_item;
    logic                 r_out_valid;
    tzda_pkg::t_out_item  r_out_item;
    tzda_pkg::t_out_item  n_out_item;
    logic                 advance;

    // offset registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias_hours   <= '0;
            r_bias_minutes <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tzda_pkg::CFG_BIAS_HOURS:   r_bias_hours   <= i_cfg_wdata[4:0];
                tzda_pkg::CFG_BIAS_MINUTES: r_bias_minutes <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // stage handshake: result register frees when empty or taken
    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_data;
        end
    end

    // adjust logic
    tzda_adjust u_adjust (
        .i_item         (r_in_item),
        .i_bias_hours   (r_bias_hours),
        .i_bias_minutes (r_bias_minutes),
        .o_item         (n_out_item)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

endmodule

>>> verif/tzda_adjust_checker.sv
// request and result monitor that predicts adjusted timestamps and compares them
module tzda_adjust_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  tzda_pkg::t_in_item  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  tzda_pkg::t_out_item i_out_data,
    input  logic                i_cfg_we,
    input  logic [0:0]          i_cfg_index,
    input  logic [6:0]          i_cfg_wdata,
    output int                  o_fail_count,
    output int                  o_pending
);

    // local copy of the offset registers
    logic signed [4:0] bias_hours_q;
    logic signed [6:0] bias_minutes_q;

    // adjusted timestamps still waiting for their result
    tzda_pkg::t_out_item adjusted_q[$];
    tzda_pkg::t_out_item oldest_adjusted;
    int                  fail_total = 0;

    assign o_fail_count = fail_total;

    // gregorian leap rule
    function automatic bit is_leap_year(input int year);
        return (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
    endfunction

    // zero for a month number outside 1..12
    function automatic int days_in_month(input int year, input int month);
        case (month)
            tzda_pkg::MONTH_JAN, tzda_pkg::MONTH_MAR, tzda_pkg::MONTH_MAY,
            tzda_pkg::MONTH_JUL, tzda_pkg::MONTH_AUG, tzda_pkg::MONTH_OCT,
            tzda_pkg::MONTH_DEC: return 31;
            tzda_pkg::MONTH_APR, tzda_pkg::MONTH_JUN, tzda_pkg::MONTH_SEP,
            tzda_pkg::MONTH_NOV: return 30;
            tzda_pkg::MONTH_FEB: return is_leap_year(year) ? 29 : 28;
            default: return 0;
        endcase
    endfunction

    // add the offset with one wrap per field, carry rippling upward
    function automatic tzda_pkg::t_out_item adjust_timestamp(
        input tzda_pkg::t_in_item request,
        input logic signed [4:0]  bias_hours,
        input logic signed [6:0]  bias_minutes
    );
        int                  year;
        int                  month;
        int                  day;
        int                  hour;
        int                  minute;
        int                  carry;
        int                  month_days;
        int                  prev_days;
        tzda_pkg::t_out_item adjusted;
        year   = int'(request.in_year);
        month  = int'(request.in_month);
        day    = int'(request.in_day);
        hour   = int'(request.in_hour);
        minute = int'(request.in_minute);

        // minute
        minute = minute + int'(bias_minutes);
        carry  = 0;
        if (minute < 0) begin
            minute = minute + 60;
            carry  = -1;
        end else if (minute > 59) begin
            minute = minute - 60;
            carry  = 1;
        end

        // hour
        hour  = hour + int'(bias_hours) + carry;
        carry = 0;
        if (hour < 0) begin
            hour  = hour + 24;
            carry = -1;
        end else if (hour > 23) begin
            hour  = hour - 24;
            carry = 1;
        end

        // date fields only move for a real month
        month_days = days_in_month(year, month);
        if (month_days != 0) begin
            prev_days = (month == tzda_pkg::MONTH_JAN) ? 31 : days_in_month(year, month - 1);
            day   = day + carry;
            carry = 0;
            if (day < 1) begin
                day   = day + prev_days;
                carry = -1;
            end else if (day > month_days) begin
                day   = day - month_days;
                carry = 1;
            end
            month = month + carry;
            carry = 0;
            if (month < 1) begin
                month = month + 12;
                carry = -1;
            end else if (month > 12) begin
                month = month - 12;
                carry = 1;
            end
            year = year + carry;
            if (year < int'(tzda_pkg::YEAR_MIN)) begin
                year = int'(tzda_pkg::YEAR_MIN);
            end else if (year > int'(tzda_pkg::YEAR_MAX)) begin
                year = int'(tzda_pkg::YEAR_MAX);
            end
        end

        adjusted.out_year    = year[14:0];
        adjusted.out_month   = month[3:0];
        adjusted.out_day     = day[4:0];
        adjusted.out_hour    = hour[4:0];
        adjusted.out_minute  = minute[5:0];
        adjusted.month_valid = (month_days != 0);
        return adjusted;
    endfunction

    task automatic check_field(input string field, input logic [14:0] expected,
                               input logic [14:0] actual);
        if (actual !== expected) begin
            fail_total++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, expected, actual);
        end
    endtask

    // result compare, request prediction and register tracking
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            bias_hours_q   <= '0;
            bias_minutes_q <= '0;
            adjusted_q.delete();
            o_pending      <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (adjusted_q.size() == 0) begin
                    fail_total++;
                    $display("%0t: result with no request waiting, expected none, actual %h",
                             $time, i_out_data);
                end else begin
                    oldest_adjusted = adjusted_q.pop_front();
                    check_field("out_year", oldest_adjusted.out_year,
                                i_out_data.out_year);
                    check_field("out_month", 15'(oldest_adjusted.out_month),
                                15'(i_out_data.out_month));
                    check_field("out_day", 15'(oldest_adjusted.out_day),
                                15'(i_out_data.out_day));
                    check_field("out_hour", 15'(oldest_adjusted.out_hour),
                                15'(i_out_data.out_hour));
                    check_field("out_minute", 15'(oldest_adjusted.out_minute),
                                15'(i_out_data.out_minute));
                    check_field("month_valid", 15'(oldest_adjusted.month_valid),
                                15'(i_out_data.month_valid));
                end
            end
            if (i_in_valid && i_in_ready) begin
                adjusted_q.push_back(adjust_timestamp(i_in_data, bias_hours_q,
                                                      bias_minutes_q));
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tzda_pkg::CFG_BIAS_HOURS:   bias_hours_q   <= i_cfg_wdata[4:0];
                    tzda_pkg::CFG_BIAS_MINUTES: bias_minutes_q <= i_cfg_wdata;
                    default: ;
                endcase
            end
            o_pending <= adjusted_q.size();
        end
    end

endmodule

>>> verif/timezone_date_time_adjust_core_test.sv
// top of the time zone adjust test: clock, reset, offset phases and request stimulus
module timezone_date_time_adjust_core_test;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 144;
    localparam int SETTLE_CYCLES   = 6;
    localparam int STRETCH_ITEMS   = 24;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    tzda_pkg::t_in_item  i_in_data   = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    tzda_pkg::t_out_item o_out_data;
    logic                i_cfg_we    = 1'b0;
    logic [0:0]          i_cfg_index = tzda_pkg::CFG_BIAS_HOURS;
    logic [6:0]          i_cfg_wdata = '0;

    int fail_count;
    int pending_results;
    int cycle_count   = 0;
    bit tx_idle_en    = 1'b1;
    bit rx_idle_en    = 1'b1;
    int rx_stall_left = 0;

    // offset settings per random phase, the last one drawn at random
    int phase_hours[NUM_PHASES]   = '{0, 14, -14, 5, -5, 15, -16, 0};
    int phase_minutes[NUM_PHASES] = '{0, 59, -59, 30, -30, 63, -64, 0};
    int century_years[8]          = '{1600, 1700, 1900, 2000, 2100, 2400, 2024, 2023};

    always #5 i_clk = ~i_clk;

    timezone_date_time_adjust_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    tzda_adjust_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side back-pressure in random bursts
    always @(posedge i_clk) begin
        if (rx_stall_left > 0) begin
            i_out_ready <= 1'b0;
            rx_stall_left--;
        end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
            i_out_ready   <= 1'b0;
            rx_stall_left = $urandom_range(0, 6);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    function automatic tzda_pkg::t_in_item make_request(input int year, input int month,
                                                        input int day, input int hour,
                                                        input int minute);
        tzda_pkg::t_in_item request;
        request.in_year   = year[14:0];
        request.in_month  = month[3:0];
        request.in_day    = day[4:0];
        request.in_hour   = hour[4:0];
        request.in_minute = minute[5:0];
        return request;
    endfunction

    // mostly well-formed timestamps leaning on field edges and leap years
    function automatic tzda_pkg::t_in_item random_request();
        tzda_pkg::t_in_item request;
        case ($urandom_range(0, 7))
            0:       request.in_year = 15'($urandom_range(0, 32767));
            1:       request.in_year = 15'($urandom_range(1601, 1602));
            2:       request.in_year = 15'($urandom_range(30826, 30827));
            3:       request.in_year = 15'(century_years[$urandom_range(0, 7)]);
            default: request.in_year = 15'($urandom_range(1601, 30827));
        endcase
        if ($urandom_range(0, 9) == 0) begin
            request.in_month = 4'($urandom_range(0, 15));
        end else begin
            request.in_month = 4'($urandom_range(1, 12));
        end
        case ($urandom_range(0, 9))
            0, 1, 2: request.in_day = 5'd1;
            3, 4:    request.in_day = 5'($urandom_range(28, 31));
            5:       request.in_day = 5'($urandom_range(0, 31));
            default: request.in_day = 5'($urandom_range(1, 31));
        endcase
        case ($urandom_range(0, 9))
            0, 1:    request.in_hour = 5'd0;
            2, 3:    request.in_hour = 5'd23;
            4:       request.in_hour = 5'($urandom_range(0, 31));
            default: request.in_hour = 5'($urandom_range(0, 23));
        endcase
        case ($urandom_range(0, 9))
            0, 1:    request.in_minute = 6'd0;
            2, 3:    request.in_minute = 6'd59;
            4:       request.in_minute = 6'($urandom_range(0, 63));
            default: request.in_minute = 6'($urandom_range(0, 59));
        endcase
        return request;
    endfunction

    // hold the request until the block takes it
    task automatic send_request(input tzda_pkg::t_in_item request);
        i_in_valid <= 1'b1;
        i_in_data  <= request;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // stop sending and wait out every outstanding result
    task automatic drain_results(input int extra_cycles);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (extra_cycles) @(posedge i_clk);
    endtask

    // both offset registers, upper bits of the hour word are don't-care
    task automatic write_bias(input int hours, input int minutes);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= tzda_pkg::CFG_BIAS_HOURS;
        i_cfg_wdata <= {2'($urandom), 5'(hours)};
        @(posedge i_clk);
        i_cfg_index <= tzda_pkg::CFG_BIAS_MINUTES;
        i_cfg_wdata <= 7'(minutes);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin : stimulus
        int sign;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset offset of zero: range edges and bad month numbers
        send_request(make_request(1601, 1, 1, 0, 0));
        send_request(make_request(30827, 12, 31, 23, 59));
        send_request(make_request(0, 0, 0, 0, 0));
        send_request(make_request(32767, 15, 31, 31, 63));
        send_request(make_request(2024, 13, 15, 12, 30));
        send_request(make_request(2024, 14, 1, 23, 59));
        drain_results(SETTLE_CYCLES);

        // forward offset of 14 hours 59 minutes: carries, leap days, year saturation high
        write_bias(14, 59);
        send_request(make_request(30827, 12, 31, 23, 59));
        send_request(make_request(2000, 2, 28, 22, 0));
        send_request(make_request(2000, 2, 29, 23, 30));
        send_request(make_request(1900, 2, 28, 23, 0));
        send_request(make_request(2024, 4, 30, 12, 1));
        send_request(make_request(2023, 12, 31, 9, 1));
        send_request(make_request(2023, 6, 15, 23, 59));
        send_request(make_request(2023, 3, 10, 0, 0));
        drain_results(SETTLE_CYCLES);

        // backward offset of 14 hours 59 minutes: borrows into previous month, saturation low
        write_bias(-14, -59);
        send_request(make_request(1601, 1, 1, 0, 0));
        send_request(make_request(2000, 3, 1, 0, 0));
        send_request(make_request(1900, 3, 1, 5, 0));
        send_request(make_request(2024, 5, 1, 13, 58));
        send_request(make_request(2024, 1, 1, 13, 59));
        send_request(make_request(2023, 6, 15, 14, 59));
        send_request(make_request(2025, 0, 1, 0, 0));
        send_request(make_request(2400, 3, 1, 0, 0));
        drain_results(SETTLE_CYCLES);

        // random phases, one offset setting each
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase == NUM_PHASES - 1) begin
                sign = ($urandom_range(0, 1) == 0) ? 1 : -1;
                phase_hours[phase]   = sign * $urandom_range(0, 14);
                phase_minutes[phase] = sign * $urandom_range(0, 59);
            end
            write_bias(phase_hours[phase], phase_minutes[phase]);
            for (int item = 0; item < ITEMS_PER_PHASE; item++) begin
                // idling on or off per stretch, none at all in the last phase
                if (item % STRETCH_ITEMS == 0) begin
                    tx_idle_en = (phase != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
                    rx_idle_en = (phase != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
                end
                // sender holds off until the pipeline is empty
                if (phase == 3 && item == ITEMS_PER_PHASE / 2) begin
                    drain_results(0);
                end
                send_request(random_request());
                if (tx_idle_en && $urandom_range(0, 4) == 0) begin
                    i_in_valid <= 1'b0;
                    repeat ($urandom_range(1, 7)) @(posedge i_clk);
                end
            end
            drain_results(SETTLE_CYCLES);
        end

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
